// ----- design/mme_pkg.sv -----
// Shared types, constants and the Michael block function for the MIC engine.
package mme_pkg;

    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [1:0] REG_VERIFY   = 2'd2;

    localparam logic [31:0] PAD_BYTE = 32'h0000_005a;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int MAX_WORDS = 6;
    localparam int WIDX_W    = $clog2(MAX_WORDS);

    typedef struct packed {
        logic        operation;
        logic        to_ds;
        logic        from_ds;
        logic        is_qos_data;
        logic [3:0]  traffic_id;
        logic [47:0] addr1;
        logic [47:0] addr2;
        logic [47:0] addr3;
        logic [47:0] addr4;
        logic [63:0] peer_mic;
        logic [7:0]  data_byte;
        logic        last_byte;
    } mme_in_t;

    typedef struct packed {
        logic [63:0] mic_value;
        logic        mic_mismatch;
    } mme_out_t;

    // One job for the round engine: a list of words to run, in order.
    typedef struct packed {
        logic                         load_key;
        logic                         emit;
        logic [WIDX_W-1:0]            nwords;
        logic [63:0]                  peer;
        logic [MAX_WORDS-1:0][31:0]   words;
    } mme_cmd_t;

    // Michael block function; returns {right, left}.
    function automatic logic [63:0] michael_round(input logic [31:0] l_in,
                                                  input logic [31:0] r_in,
                                                  input logic [31:0] w);
        logic [31:0] l;
        logic [31:0] r;
        l = l_in ^ w;
        r = r_in;
        r = r ^ {l[14:0], l[31:15]};
        l = l + r;
        r = r ^ {l[23:16], l[31:24], l[7:0], l[15:8]};
        l = l + r;
        r = r ^ {l[28:0], l[31:29]};
        l = l + r;
        r = r ^ {l[1:0], l[31:2]};
        l = l + r;
        return {r, l};
    endfunction

endpackage

// ----- design/mme_front.sv -----
// Front end: tracks frame state, packs bytes into words, queues round jobs.
module mme_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_accept,
    input  mme_pkg::mme_in_t  in_item,
    output logic              push,
    output mme_pkg::mme_cmd_t push_cmd
);

    logic        in_frame_reg, in_frame_next;
    logic [23:0] collect_reg, collect_next;
    logic [1:0]  phase_reg, phase_next;

    logic [47:0] da, sa;
    logic [3:0]  prio;
    logic [23:0] merged;
    logic [1:0]  phase_inc;

    always_comb begin
        case ({in_item.from_ds, in_item.to_ds})
            2'b00:   begin da = in_item.addr1; sa = in_item.addr2; end
            2'b01:   begin da = in_item.addr3; sa = in_item.addr2; end
            2'b10:   begin da = in_item.addr1; sa = in_item.addr3; end
            default: begin da = in_item.addr3; sa = in_item.addr4; end
        endcase
        prio      = in_item.is_qos_data ? in_item.traffic_id : 4'd0;
        merged    = collect_reg | ({16'd0, in_item.data_byte} << {phase_reg, 3'b000});
        phase_inc = phase_reg + 2'd1;

        in_frame_next     = in_frame_reg;
        collect_next      = collect_reg;
        phase_next        = phase_reg;
        push              = 1'b0;
        push_cmd          = '0;
        push_cmd.peer     = in_item.peer_mic;

        if (in_accept) begin
            if (in_item.operation == mme_pkg::OP_BEGIN) begin
                push              = 1'b1;
                push_cmd.load_key = 1'b1;
                push_cmd.words[0] = da[31:0];
                push_cmd.words[1] = {sa[15:0], da[47:32]};
                push_cmd.words[2] = sa[47:16];
                push_cmd.words[3] = {28'd0, prio};
                if (in_item.last_byte) begin
                    push_cmd.emit     = 1'b1;
                    push_cmd.words[4] = mme_pkg::PAD_BYTE;
                    push_cmd.nwords   = 3'd6;
                end else begin
                    push_cmd.nwords   = 3'd4;
                end
                in_frame_next = !in_item.last_byte;
                collect_next  = '0;
                phase_next    = '0;
            end else if (in_frame_reg) begin
                if (phase_reg == 2'd3) begin
                    // word complete: run it, then padding if this ends the frame
                    push              = 1'b1;
                    push_cmd.words[0] = {in_item.data_byte, collect_reg};
                    if (in_item.last_byte) begin
                        push_cmd.emit     = 1'b1;
                        push_cmd.words[1] = mme_pkg::PAD_BYTE;
                        push_cmd.nwords   = 3'd3;
                    end else begin
                        push_cmd.nwords   = 3'd1;
                    end
                    collect_next = '0;
                    phase_next   = '0;
                end else if (in_item.last_byte) begin
                    push              = 1'b1;
                    push_cmd.emit     = 1'b1;
                    push_cmd.words[0] = {8'd0, merged} |
                                        (mme_pkg::PAD_BYTE << {phase_inc, 3'b000});
                    push_cmd.nwords   = 3'd2;
                    collect_next      = '0;
                    phase_next        = '0;
                end else begin
                    collect_next = merged;
                    phase_next   = phase_inc;
                end
                if (in_item.last_byte) begin
                    in_frame_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            collect_reg  <= '0;
            phase_reg    <= '0;
        end else begin
            in_frame_reg <= in_frame_next;
            collect_reg  <= collect_next;
            phase_reg    <= phase_next;
        end
    end

endmodule

// ----- design/mme_queue.sv -----
// Small register FIFO of round jobs between front end and round engine.
module mme_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  mme_pkg::mme_cmd_t push_cmd,
    input  logic              pop,
    output mme_pkg::mme_cmd_t head,
    output logic              empty,
    output logic              full
);

    mme_pkg::mme_cmd_t                    slot_reg [mme_pkg::QUEUE_DEPTH];
    logic [mme_pkg::QPTR_W-1:0]           wr_ptr_reg, rd_ptr_reg;
    logic [mme_pkg::QCNT_W-1:0]           count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == mme_pkg::QCNT_W'(mme_pkg::QUEUE_DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- design/mme_back.sv -----
// Round engine (one Michael block per cycle unless the emit stage stalls it), emit stage, result register.
module mme_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [31:0]       key_low_word,
    input  logic [31:0]       key_high_word,
    input  logic              verify_mode,
    input  mme_pkg::mme_cmd_t head,
    input  logic              empty,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output mme_pkg::mme_out_t m_payload
);

    logic [31:0]                left_reg, right_reg;
    logic [63:0]                peer_reg;
    logic [mme_pkg::WIDX_W-1:0] idx_reg;

    logic        stage_valid_reg;
    logic [63:0] stage_mic_reg;
    logic [63:0] stage_peer_reg;

    logic              out_valid_reg;
    mme_pkg::mme_out_t out_reg;

    logic        first;
    logic        last_round;
    logic        out_free;
    logic        stage_free;
    logic        step;
    logic [31:0] l_in, r_in;
    logic [63:0] round_out;
    logic [63:0] peer_cur;

    always_comb begin
        first      = (idx_reg == '0) && head.load_key;
        l_in       = first ? key_low_word  : left_reg;
        r_in       = first ? key_high_word : right_reg;
        peer_cur   = first ? head.peer     : peer_reg;
        round_out  = mme_pkg::michael_round(l_in, r_in, head.words[idx_reg]);
        last_round = (idx_reg == head.nwords - 3'd1);
        out_free   = !out_valid_reg || m_ready;
        stage_free = !stage_valid_reg || out_free;
        step       = !empty && (!(last_round && head.emit) || stage_free);
        pop        = step && last_round;
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            left_reg  <= round_out[31:0];
            right_reg <= round_out[63:32];
            peer_reg  <= peer_cur;
        end
        if (step && last_round && head.emit) begin
            stage_mic_reg  <= round_out;
            stage_peer_reg <= peer_cur;
        end
        if (stage_valid_reg && out_free) begin
            out_reg.mic_value    <= stage_mic_reg;
            out_reg.mic_mismatch <= verify_mode && (stage_mic_reg != stage_peer_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg         <= '0;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (step) begin
                idx_reg <= last_round ? '0 : idx_reg + 1'b1;
            end
            if (step && last_round && head.emit) begin
                stage_valid_reg <= 1'b1;
            end else if (out_free) begin
                stage_valid_reg <= 1'b0;
            end
            if (stage_valid_reg && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

endmodule

// ----- design/michael_mic_engine.sv -----
// Top level of the TKIP Michael MIC engine: register port, front end, queue, round engine.
//
// Usage: program the 64-bit key (key_low_word at 0x0, key_high_word at 0x4) and
// verify_mode (0x8) over the APB port while the engine is idle. Each frame
// starts with a begin beat on s_ (operation 0) carrying DS bits, QoS/TID, the
// four addresses and, for receive checking, the peer MIC. Data beats
// (operation 1) follow with one payload byte each; last_byte marks the final
// byte (on a begin beat it means an empty payload). A data beat outside a
// frame is dropped; a begin inside a frame restarts.
// Throughput: one input beat per cycle for payload bytes while the job queue
// is not full. The round engine runs one Michael block per cycle unless an
// emitting final block waits on a busy emit stage; a begin costs four blocks,
// every fourth byte one, and the frame end two (three if it completes a word);
// short frames back to back are set by that engine. Result path: the final
// block loads the emit stage, then the result register behind m_valid. A
// four-entry job queue decouples the byte intake from the engine; s_ready drops
// when full. Stalls: when m_ready is low the result holds in the output register,
// the emit stage holds one more, and then the engine and queue back up to s_ready.
// Reset (aresetn, synchronous) clears config, frame state, queue and valid flags.
module michael_mic_engine (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  mme_pkg::mme_in_t              s_payload,

    output logic                          m_valid,
    input  logic                          m_ready,
    output mme_pkg::mme_out_t             m_payload,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mme_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [31:0] key_low_reg;
    logic [31:0] key_high_reg;
    logic        verify_reg;

    logic              cfg_write;
    logic              in_accept;
    logic              push;
    logic              pop;
    logic              q_empty;
    logic              q_full;
    mme_pkg::mme_cmd_t push_cmd;
    mme_pkg::mme_cmd_t head;

    // register port: zero wait states
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            verify_reg   <= 1'b0;
        end else if (cfg_write) begin
            case (paddr[3:2])
                mme_pkg::REG_KEY_LOW:  key_low_reg  <= pwdata;
                mme_pkg::REG_KEY_HIGH: key_high_reg <= pwdata;
                mme_pkg::REG_VERIFY:   verify_reg   <= pwdata[0];
                default:               ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            mme_pkg::REG_KEY_LOW:  prdata = key_low_reg;
            mme_pkg::REG_KEY_HIGH: prdata = key_high_reg;
            mme_pkg::REG_VERIFY:   prdata = {31'd0, verify_reg};
            default:               prdata = '0;
        endcase
    end

    // intake stalls only on a full job queue
    assign s_ready   = !q_full;
    assign in_accept = s_valid && s_ready;

    mme_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_item   (s_payload),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    mme_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    mme_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .key_low_word  (key_low_reg),
        .key_high_word (key_high_reg),
        .verify_mode   (verify_reg),
        .head          (head),
        .empty         (q_empty),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_payload     (m_payload)
    );

endmodule
